FILE: rtl/core/b64d_pkg.sv
// shared types, constants and the character map for the base64 stream decoder
`default_nettype none
package b64d_pkg;

   localparam int BURST_DEPTH = 6;
   localparam int BURST_IDX_W = 3;

   localparam logic [7:0] CHAR_PAD   = 8'h3D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [5:0] VAL_PLUS   = 6'd62;
   localparam logic [5:0] VAL_SLASH  = 6'd63;
   localparam logic [5:0] OFS_LOWER  = 6'd26;
   localparam logic [5:0] OFS_DIGIT  = 6'd52;

   typedef struct packed {
      logic       kept;
      logic       is_pad;
      logic [5:0] value;
   } sextet_type;

   typedef struct packed {
      logic [BURST_DEPTH-1:0][7:0] data;
      logic [BURST_DEPTH-1:0]      valid;
      logic [BURST_DEPTH-1:0]      last;
      logic [BURST_IDX_W-1:0]      count;
   } burst_type;

   function automatic sextet_type char_value(input logic [7:0] ch);
      sextet_type s;
      s = '0;
      if (ch >= 8'h41 && ch <= 8'h5A) begin
         s.kept  = 1'b1;
         s.value = 6'(ch - 8'h41);
      end else if (ch >= 8'h61 && ch <= 8'h7A) begin
         s.kept  = 1'b1;
         s.value = 6'(ch - 8'h61) + OFS_LOWER;
      end else if (ch >= 8'h30 && ch <= 8'h39) begin
         s.kept  = 1'b1;
         s.value = 6'(ch - 8'h30) + OFS_DIGIT;
      end else if (ch == CHAR_PLUS) begin
         s.kept  = 1'b1;
         s.value = VAL_PLUS;
      end else if (ch == CHAR_SLASH) begin
         s.kept  = 1'b1;
         s.value = VAL_SLASH;
      end else if (ch == CHAR_PAD) begin
         s.kept   = 1'b1;
         s.is_pad = 1'b1;
      end
      return s;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/b64d_group.sv
// group assembly, held group and burst build for one request
`default_nettype none
module b64d_group (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire logic [7:0]          text_char,
   input  wire logic                end_of_text,
   output b64d_pkg::burst_type      burst
);

   logic [17:0] accum_ff, accum_in;
   logic [1:0]  cig_ff, cig_in;
   logic [2:0]  pad_ff, pad_in;
   logic [23:0] held_ff, held_in;
   logic        held_vld_ff, held_vld_in;
   logic [2:0]  held_pad_ff, held_pad_in;

   b64d_pkg::sextet_type sx;
   logic [2:0]  pad_next;
   logic        complete;
   logic [23:0] group;
   logic [23:0] nh_bytes;
   logic        nh_valid;
   logic [2:0]  nh_pad;
   logic [1:0]  cnt_end;
   logic [2:0]  base;

   always_comb begin
      sx       = b64d_pkg::char_value(text_char);
      pad_next = sx.is_pad ? pad_ff + 3'd1 : 3'd0;
      complete = sx.kept && (cig_ff == 2'd3);
      group    = {accum_ff, sx.value};
      nh_bytes = complete ? group : held_ff;
      nh_valid = complete | held_vld_ff;
      nh_pad   = complete ? pad_next : held_pad_ff;
      if (!nh_valid) begin
         cnt_end = 2'd0;
      end else if (nh_pad >= 3'd3) begin
         cnt_end = 2'd0;
      end else begin
         cnt_end = 2'd3 - nh_pad[1:0];
      end
   end

   // burst: optional flush of the previous group, then the end bytes or empty marker
   always_comb begin
      burst = '0;
      base  = 3'd0;
      if (complete && held_vld_ff) begin
         burst.data[0]  = held_ff[23:16];
         burst.data[1]  = held_ff[15:8];
         burst.data[2]  = held_ff[7:0];
         burst.valid[2:0] = 3'b111;
         base = 3'd3;
      end
      burst.count = base;
      if (end_of_text) begin
         if (cnt_end == 2'd0) begin
            burst.last[base] = 1'b1;
            burst.count      = base + 3'd1;
         end else begin
            for (int i = 0; i < 3; i++) begin
               if (2'(i) < cnt_end) begin
                  burst.data[base + 3'(i)]  = nh_bytes[23 - 8*i -: 8];
                  burst.valid[base + 3'(i)] = 1'b1;
                  burst.last[base + 3'(i)]  = (2'(i) == cnt_end - 2'd1);
               end
            end
            burst.count = base + {1'b0, cnt_end};
         end
      end
   end

   always_comb begin
      accum_in    = accum_ff;
      cig_in      = cig_ff;
      pad_in      = pad_ff;
      held_in     = held_ff;
      held_vld_in = held_vld_ff;
      held_pad_in = held_pad_ff;
      if (end_of_text) begin
         accum_in    = '0;
         cig_in      = '0;
         pad_in      = '0;
         held_in     = '0;
         held_vld_in = 1'b0;
         held_pad_in = '0;
      end else if (complete) begin
         held_in     = group;
         held_vld_in = 1'b1;
         held_pad_in = pad_next;
         accum_in    = '0;
         cig_in      = '0;
         pad_in      = '0;
      end else if (sx.kept) begin
         accum_in = {accum_ff[11:0], sx.value};
         cig_in   = cig_ff + 2'd1;
         pad_in   = pad_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff    <= '0;
         cig_ff      <= '0;
         pad_ff      <= '0;
         held_ff     <= '0;
         held_vld_ff <= 1'b0;
         held_pad_ff <= '0;
      end else if (fire) begin
         accum_ff    <= accum_in;
         cig_ff      <= cig_in;
         pad_ff      <= pad_in;
         held_ff     <= held_in;
         held_vld_ff <= held_vld_in;
         held_pad_ff <= held_pad_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/b64d_out.sv
// result burst register, sends one byte per cycle while the result port is ready
`default_nettype none
module b64d_out (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire b64d_pkg::burst_type burst,
   output logic                     free,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [7:0]               rsp_data_byte,
   output logic                     rsp_byte_valid,
   output logic                     rsp_last_byte
);

   b64d_pkg::burst_type               buf_ff;
   logic [b64d_pkg::BURST_IDX_W-1:0]  cnt_ff, cnt_in;
   logic [b64d_pkg::BURST_IDX_W-1:0]  idx_ff, idx_in;
   logic                              take;
   logic                              final_take;

   assign rsp_valid      = (cnt_ff != '0);
   assign take           = rsp_valid && rsp_ready;
   assign final_take     = take && (idx_ff + 3'd1 == cnt_ff);
   assign free           = !rsp_valid || final_take;
   assign rsp_data_byte  = buf_ff.data[idx_ff];
   assign rsp_byte_valid = buf_ff.valid[idx_ff];
   assign rsp_last_byte  = buf_ff.last[idx_ff];

   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (load) begin
         cnt_in = burst.count;
         idx_in = '0;
      end else if (final_take) begin
         cnt_in = '0;
         idx_in = '0;
      end else if (take) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         buf_ff <= burst;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/base64_stream_decoder.sv
// top level: request register, group decoder and result burst register
`default_nettype none
// Base64 stream decoder. Takes one character per request, skips anything outside the
// base64 alphabet and padding, and returns decoded bytes one per result. A request is
// held in an input register, then decoded against the running group state; its results
// (up to six: three bytes of the previous group plus up to three end bytes, or one
// empty end marker) are loaded into a burst register and sent one per cycle while the
// result port is ready. Characters that yield no result or one result flow at one per
// cycle while the result port is ready; a request that yields more keeps the burst
// register busy until all are sent, so the request after it waits, longer when the
// result port stalls. A request passes the input register, then the burst register,
// before its first result is on the result port.
module base64_stream_decoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_text_char,
   input  wire logic       req_end_of_text,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_data_byte,
   output logic            rsp_byte_valid,
   output logic            rsp_last_byte
);

   logic                in_vld_ff, in_vld_in;
   logic [7:0]          in_char_ff;
   logic                in_end_ff;
   logic                out_free;
   logic                fire;
   b64d_pkg::burst_type burst;

   assign fire      = in_vld_ff && out_free;
   assign req_ready = !in_vld_ff || fire;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
      end else if (fire) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_text_char;
         in_end_ff  <= req_end_of_text;
      end
   end

   b64d_group u_group (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .text_char   (in_char_ff),
      .end_of_text (in_end_ff),
      .burst       (burst)
   );

   b64d_out u_out (
      .clock          (clock),
      .reset          (reset),
      .load           (fire),
      .burst          (burst),
      .free           (out_free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule
`default_nettype wire

FILE: verif/b64d_checker.sv
// result checker for the base64 stream decoder: predicts decoded bytes and compares them
`timescale 1ns / 1ps
module b64d_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_text_char,
   input  logic       req_end_of_text,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_data_byte,
   input  logic       rsp_byte_valid,
   input  logic       rsp_last_byte,
   output int         fail_count,
   output int         bytes_pending,
   output int         bytes_checked
);

   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       last;
   } decoded_byte_type;

   decoded_byte_type decoded_bytes[$];
   decoded_byte_type want;

   logic [17:0] open_sextets;
   logic [1:0]  open_count;
   logic [2:0]  open_pad;
   logic [23:0] held_group;
   logic        held_ok;
   logic [2:0]  held_pad;

   // {kept, sextet value}
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) return {1'b1, 6'(c - 8'h41)};
      if (c >= 8'h61 && c <= 8'h7A) return {1'b1, 6'(c - 8'h61) + b64d_pkg::OFS_LOWER};
      if (c >= 8'h30 && c <= 8'h39) return {1'b1, 6'(c - 8'h30) + b64d_pkg::OFS_DIGIT};
      if (c == b64d_pkg::CHAR_PLUS) return {1'b1, b64d_pkg::VAL_PLUS};
      if (c == b64d_pkg::CHAR_SLASH) return {1'b1, b64d_pkg::VAL_SLASH};
      if (c == b64d_pkg::CHAR_PAD) return {1'b1, 6'd0};
      return 7'd0;
   endfunction

   task automatic clear_groups();
      open_sextets = '0;
      open_count   = '0;
      open_pad     = '0;
      held_group   = '0;
      held_ok      = 1'b0;
      held_pad     = '0;
   endtask

   task automatic decode_char(input logic [7:0] c, input logic eot);
      logic [6:0] s;
      int unsigned n;
      s = sextet_of(c);
      if (s[6]) begin
         open_pad = (c == b64d_pkg::CHAR_PAD) ? open_pad + 3'd1 : 3'd0;
         if (open_count == 2'd3) begin
            if (held_ok) begin
               for (int i = 2; i >= 0; i--)
                  decoded_bytes.push_back('{held_group[8*i +: 8], 1'b1, 1'b0});
            end
            held_group   = {open_sextets, s[5:0]};
            held_ok      = 1'b1;
            held_pad     = open_pad;
            open_sextets = '0;
            open_count   = '0;
            open_pad     = '0;
         end else begin
            open_sextets = {open_sextets[11:0], s[5:0]};
            open_count   = open_count + 2'd1;
         end
      end
      if (eot) begin
         n = held_ok ? 3 - ((held_pad > 3'd3) ? 3 : held_pad) : 0;
         if (n == 0) begin
            decoded_bytes.push_back('{8'h00, 1'b0, 1'b1});
         end else begin
            for (int i = 0; i < n; i++)
               decoded_bytes.push_back('{held_group[23-8*i -: 8], 1'b1, i == n - 1});
         end
         clear_groups();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_groups();
         decoded_bytes.delete();
         fail_count    = 0;
         bytes_checked = 0;
      end else begin
         if (req_valid && req_ready) decode_char(req_text_char, req_end_of_text);
         if (rsp_valid && rsp_ready) begin
            if (decoded_bytes.size() == 0) begin
               $error("unexpected result: data_byte %h byte_valid %b last_byte %b",
                      rsp_data_byte, rsp_byte_valid, rsp_last_byte);
               fail_count++;
            end else begin
               want = decoded_bytes.pop_front();
               bytes_checked++;
               if (rsp_data_byte !== want.data) begin
                  $error("data_byte: expected %h, got %h", want.data, rsp_data_byte);
                  fail_count++;
               end
               if (rsp_byte_valid !== want.valid) begin
                  $error("byte_valid: expected %b, got %b", want.valid, rsp_byte_valid);
                  fail_count++;
               end
               if (rsp_last_byte !== want.last) begin
                  $error("last_byte: expected %b, got %b", want.last, rsp_last_byte);
                  fail_count++;
               end
            end
         end
      end
      bytes_pending = decoded_bytes.size();
   end

endmodule

FILE: verif/tb.sv
// testbench top for the base64 stream decoder: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_text_char;
   logic       req_end_of_text;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_data_byte;
   logic       rsp_byte_valid;
   logic       rsp_last_byte;

   int fail_count;
   int bytes_pending;
   int bytes_checked;

   int burst_left;
   int gap_len;
   int stall_len;
   int cycle_count;
   int texts_sent;
   int kept_sent;
   int random_start;
   int long_holds;
   logic [7:0] text_buf[$];

   base64_stream_decoder dut (.*);

   b64d_checker decode_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) cycle_count++;

   function automatic bit is_kept(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
             (c >= 8'h30 && c <= 8'h39) || c == b64d_pkg::CHAR_PLUS ||
             c == b64d_pkg::CHAR_SLASH || c == b64d_pkg::CHAR_PAD;
   endfunction

   function automatic logic [7:0] b64_char();
      int unsigned r;
      r = $urandom_range(0, 63);
      if (r < 26) return 8'(8'h41 + r);
      if (r < 52) return 8'(8'h61 + r - 26);
      if (r < 62) return 8'(8'h30 + r - 52);
      return (r == 62) ? b64d_pkg::CHAR_PLUS : b64d_pkg::CHAR_SLASH;
   endfunction

   function automatic logic [7:0] junk_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      while (is_kept(c)) c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   task automatic send_char(input logic [7:0] c, input logic eot);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap_len > 0) begin
            req_valid <= 1'b0;
            repeat (gap_len) @(negedge clock);
         end
      end
      req_valid       <= 1'b1;
      req_text_char   <= c;
      req_end_of_text <= eot;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      burst_left--;
      if (is_kept(c)) kept_sent++;
   endtask

   task automatic send_text();
      if (text_buf.size() == 0) text_buf.push_back(junk_char());
      foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1);
      text_buf.delete();
      texts_sent++;
   endtask

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endtask

   // occasional skipped character ahead of a kept one
   task automatic add_kept(input logic [7:0] c);
      if ($urandom_range(0, 9) == 0) text_buf.push_back(junk_char());
      text_buf.push_back(c);
   endtask

   task automatic random_text();
      int kind;
      int pads;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         repeat ($urandom_range(1, 12)) text_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(0, 9) == 0 ? $urandom_range(4, 8) : $urandom_range(0, 3))
            repeat (4) add_kept(b64_char());
         case (kind)
            1: repeat ($urandom_range(1, 3)) add_kept(b64_char());
            2: repeat (4)
               add_kept(($urandom_range(0, 2) == 0) ? b64d_pkg::CHAR_PAD : b64_char());
            3, 4: begin
               pads = ($urandom_range(0, 7) == 0) ? 4 : $urandom_range(1, 3);
               repeat (4 - pads) add_kept(b64_char());
               repeat (pads) add_kept(b64d_pkg::CHAR_PAD);
            end
            default: ;
         endcase
         if ($urandom_range(0, 7) == 0) text_buf.push_back(junk_char());
      end
      send_text();
   endtask

   // receiver: random ready pattern plus long holds that back up the decoder
   initial begin
      rsp_ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if ((long_holds == 0 && cycle_count > 300) || $urandom_range(0, 59) == 0) begin
            rsp_ready <= 1'b0;
            long_holds++;
            repeat (150) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         repeat (($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8))
            @(negedge clock);
         stall_len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 5);
         if (stall_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall_len) @(negedge clock);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("[base64_stream_decoder] ERROR");
      $finish;
   end

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_text_char   = 8'h00;
      req_end_of_text = 1'b0;
      burst_left      = 0;
      cycle_count     = 0;
      texts_sent      = 0;
      kept_sent       = 0;
      long_holds      = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // skipped character that ends an empty text
      text_buf.push_back(8'h00);
      send_text();
      // alphabet extremes, held group flushed, final group with one pad
      add_str("+/9zAZazTWE=");
      send_text();
      // pad inside a group, then a skipped last character
      add_str("AB=C");
      text_buf.push_back(8'hFF);
      send_text();
      // padding running across two groups
      add_str("AB======");
      send_text();
      // two pads in the final group, partial group dropped
      add_str("TQ==QU");
      send_text();

      random_start = kept_sent;
      while (kept_sent - random_start < 450) random_text();
      req_valid <= 1'b0;

      while (bytes_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("run covered %0d texts, %0d base64 characters, %0d results, %0d long holds",
               texts_sent, kept_sent, bytes_checked, long_holds);
      if (fail_count == 0)
         $display("[base64_stream_decoder] OK");
      else
         $display("[base64_stream_decoder] ERROR");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/b64d_pkg.sv
rtl/core/b64d_group.sv
rtl/core/b64d_out.sv
rtl/core/base64_stream_decoder.sv
verif/b64d_checker.sv
verif/tb.sv
